@@ sv/radial_smoothstep_height_falloff_macros.svh @@
// assertion macros shared by the radial falloff rtl
// no dependencies; included by the modules that carry checks
`ifndef RADIAL_SMOOTHSTEP_HEIGHT_FALLOFF_MACROS_SVH
`define RADIAL_SMOOTHSTEP_HEIGHT_FALLOFF_MACROS_SVH

// same-cycle implication
`define RSHF_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RSHF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/rshf_pkg.sv @@
// shared types and fixed constants of the radial falloff block
// no dependencies
package rshf_pkg;

   // falloff factor t is unsigned q1.16
   localparam int unsigned T_BITS = 16;
   localparam logic [T_BITS:0]   ONE_T   = {1'b1, {T_BITS{1'b0}}};
   localparam logic [T_BITS+1:0] THREE_T = {2'b11, {T_BITS{1'b0}}};
   localparam logic [T_BITS-1:0] HALF_T  = {1'b1, {(T_BITS-1){1'b0}}};

   typedef enum logic {
      CSR_DISK_RADIUS = 1'b0,
      CSR_EDGE_WIDTH  = 1'b1
   } csr_index_type;

   // t forced to an end of its range
   typedef struct packed {
      logic t_zero;
      logic t_full;
   } tsel_type;

endpackage

@@ sv/rshf_sqrt.sv @@
// pipelined integer square root, one root bit per stage
// uses rshf_pkg and the assertion macro header
`include "radial_smoothstep_height_falloff_macros.svh"

module rshf_sqrt
   import rshf_pkg::*;
#(
   parameter int unsigned RW     = 16,
   parameter int unsigned SIDE_W = 16
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [2*RW-1:0]   in_radicand,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [RW-1:0]     out_root,
   output logic [SIDE_W-1:0] out_side
);

   localparam int unsigned RMW = RW + 2;

   logic              vld_ff  [RW];
   logic [RMW-1:0]    rem_ff  [RW];
   logic [RW-1:0]     root_ff [RW];
   logic [2*RW-1:0]   rad_ff  [RW];
   logic [SIDE_W-1:0] side_ff [RW];
   logic [RMW-1:0]    rem_cap;

   for (genvar k = 0; k < RW; k++) begin : g_step
      logic              vld_prev;
      logic [RMW-1:0]    rem_prev;
      logic [RW-1:0]     root_prev;
      logic [2*RW-1:0]   rad_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [RMW-1:0]    rem_sh;
      logic [RMW-1:0]    trial;
      logic              fits;
      logic [RMW-1:0]    rem_in;
      logic [RW-1:0]     root_in;

      if (k == 0) begin : g_head
         assign vld_prev  = in_valid;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = in_radicand;
         assign side_prev = in_side;
      end else begin : g_body
         assign vld_prev  = vld_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      always_comb begin
         rem_sh  = {rem_prev[RMW-3:0], rad_prev[2*(RW-1-k)+1 -: 2]};
         trial   = {root_prev, 2'b01};
         fits    = (rem_sh >= trial);
         rem_in  = fits ? (rem_sh - trial) : rem_sh;
         root_in = {root_prev[RW-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_prev;
         end
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         rad_ff[k]  <= rad_prev;
         side_ff[k] <= side_prev;
      end
   end

   assign out_valid = vld_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_side  = side_ff[RW-1];

   assign rem_cap = {1'b0, root_ff[RW-1], 1'b0};

   // final remainder n - r*r never exceeds 2r
   `RSHF_ASSERT_IMPLIES(a_sqrt_rem_bound, clock, reset, vld_ff[RW-1], rem_ff[RW-1] <= rem_cap, "sqrt remainder out of range")

endmodule

@@ sv/rshf_div.sv @@
// pipelined restoring divider for a fraction below one, one quotient bit per stage
// uses rshf_pkg and the assertion macro header
`include "radial_smoothstep_height_falloff_macros.svh"

module rshf_div
   import rshf_pkg::*;
#(
   parameter int unsigned DW     = 15,
   parameter int unsigned SIDE_W = 18
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [DW-1:0]     in_dividend,
   input  logic [DW-1:0]     divisor,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [T_BITS-1:0] out_quot,
   output logic [SIDE_W-1:0] out_side
);

   logic              vld_ff  [T_BITS];
   logic [DW-1:0]     rem_ff  [T_BITS];
   logic [T_BITS-1:0] quot_ff [T_BITS];
   logic [SIDE_W-1:0] side_ff [T_BITS];

   for (genvar k = 0; k < T_BITS; k++) begin : g_step
      logic              vld_prev;
      logic [DW-1:0]     rem_prev;
      logic [T_BITS-1:0] quot_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [DW:0]       rem_sh;
      logic [DW:0]       diff;
      logic              fits;
      logic [DW-1:0]     rem_in;
      logic [T_BITS-1:0] quot_in;

      if (k == 0) begin : g_head
         assign vld_prev  = in_valid;
         assign rem_prev  = in_dividend;
         assign quot_prev = '0;
         assign side_prev = in_side;
      end else begin : g_body
         assign vld_prev  = vld_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign quot_prev = quot_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      always_comb begin
         rem_sh  = {rem_prev, 1'b0};
         diff    = rem_sh - {1'b0, divisor};
         fits    = (rem_sh >= {1'b0, divisor});
         rem_in  = fits ? diff[DW-1:0] : rem_sh[DW-1:0];
         quot_in = {quot_prev[T_BITS-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_prev;
         end
         rem_ff[k]  <= rem_in;
         quot_ff[k] <= quot_in;
         side_ff[k] <= side_prev;
      end
   end

   assign out_valid = vld_ff[T_BITS-1];
   assign out_quot  = quot_ff[T_BITS-1];
   assign out_side  = side_ff[T_BITS-1];

   `RSHF_ASSERT_IMPLIES(a_div_rem_bound, clock, reset, vld_ff[T_BITS-1], rem_ff[T_BITS-1] < divisor, "divider remainder not below divisor")

endmodule

@@ sv/rshf_shape.sv @@
// smoothstep of t and rounded scaling of the height by 1 - s
// uses rshf_pkg and the assertion macro header
`include "radial_smoothstep_height_falloff_macros.svh"

module rshf_shape
   import rshf_pkg::*;
#(
   parameter int unsigned HW = 16
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [T_BITS-1:0] in_quot,
   input  tsel_type          in_sel,
   input  logic [HW-1:0]     in_height,
   output logic              out_valid,
   output logic [HW-1:0]     out_height
);

   localparam int unsigned TW   = T_BITS + 1;
   localparam int unsigned NSTG = 6;

   logic          vld_ff [NSTG];
   logic          neg_ff [NSTG-1];
   logic [HW-1:0] mag_ff [NSTG-2];

   logic [TW-1:0] t_ff;
   logic [TW-1:0] t2_ff;
   logic [TW:0]   fac_ff;
   logic [TW+1:0] s_ff;
   logic [TW-1:0] keep_ff;
   logic [HW-1:0] scaled_ff;
   logic [HW-1:0] out_ff;

   logic [TW-1:0]      t_in;
   logic [HW-1:0]      mag_in;
   logic [2*TW-1:0]    sq_prod;
   logic [2*TW:0]      s_prod;
   logic [TW-1:0]      keep_in;
   logic [HW+TW-1:0]   h_prod;
   logic [HW+TW-1:0]   h_rnd;
   logic [HW-1:0]      out_in;

   always_comb begin
      t_in    = in_sel.t_zero ? '0 : (in_sel.t_full ? ONE_T : {1'b0, in_quot});
      mag_in  = in_height[HW-1] ? (~in_height + 1'b1) : in_height;
      sq_prod = t_ff * t_ff;
      s_prod  = t2_ff * fac_ff;
      keep_in = (s_ff > (TW+2)'(ONE_T)) ? '0 : (ONE_T - s_ff[TW-1:0]);
      h_prod  = mag_ff[3] * keep_ff;
      h_rnd   = h_prod + (HW+TW)'(HALF_T);
      out_in  = neg_ff[4] ? (~scaled_ff + 1'b1) : scaled_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSTG; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i < NSTG; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      // t
      t_ff      <= t_in;
      neg_ff[0] <= in_height[HW-1];
      mag_ff[0] <= mag_in;
      // t squared and 3 - 2t
      t2_ff     <= sq_prod[2*T_BITS:T_BITS];
      fac_ff    <= THREE_T - {t_ff, 1'b0};
      neg_ff[1] <= neg_ff[0];
      mag_ff[1] <= mag_ff[0];
      // smoothstep
      s_ff      <= s_prod[2*TW:T_BITS];
      neg_ff[2] <= neg_ff[1];
      mag_ff[2] <= mag_ff[1];
      // 1 - s
      keep_ff   <= keep_in;
      neg_ff[3] <= neg_ff[2];
      mag_ff[3] <= mag_ff[2];
      // rounded magnitude
      scaled_ff <= h_rnd[HW+T_BITS-1:T_BITS];
      neg_ff[4] <= neg_ff[3];
      // sign restore
      out_ff    <= out_in;
   end

   assign out_valid  = vld_ff[NSTG-1];
   assign out_height = out_ff;

   `RSHF_ASSERT_NEXT(a_zero_t_flat, clock, reset, vld_ff[0] && t_ff == '0, t2_ff == '0 && fac_ff == THREE_T, "zero t gave nonzero smoothstep terms")
   `RSHF_ASSERT_NEXT(a_no_growth, clock, reset, vld_ff[3], scaled_ff <= $past(mag_ff[3]), "scaled height exceeds input magnitude")

endmodule

@@ sv/radial_smoothstep_height_falloff.sv @@
// top level of the radial smoothstep height falloff pipeline
// uses rshf_pkg, rshf_sqrt, rshf_div and rshf_shape
//
// channel   direction  ports                                       handshake
// request   in         req_x_coord, req_z_coord, req_height_in     start && !busy
// response  out        rsp_height_out                              rsp_valid strobe
// csr       in         csr_index, csr_wdata                        csr_write_en
//
// one transaction enters per cycle; busy is always low
// the square root takes one stage per root bit and the divider one stage
// per fraction bit of t
// reset is synchronous and clears only the valid bits and the csr registers
// the receiver cannot stall, so every result is shown for exactly one cycle
module radial_smoothstep_height_falloff
   import rshf_pkg::*;
#(
   parameter int unsigned COORD_BITS = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [COORD_BITS-1:0] req_x_coord,
   input  logic [COORD_BITS-1:0] req_z_coord,
   input  logic [COORD_BITS-1:0] req_height_in,
   output logic                  rsp_valid,
   output logic [COORD_BITS-1:0] rsp_height_out,
   input  logic                  csr_write_en,
   input  csr_index_type         csr_index,
   input  logic [COORD_BITS-2:0] csr_wdata
);

   localparam int unsigned CB    = COORD_BITS;
   localparam int unsigned RB    = CB - 1;
   localparam int unsigned DB    = CB + 2;
   localparam int unsigned SEL_W = $bits(tsel_type);
   localparam int unsigned SIDE_W = CB + SEL_W;
   localparam logic [RB-1:0] RADIUS_RST = RB'(1) << (CB - 3);
   localparam logic [RB-1:0] EDGE_RST   = RB'(1) << (CB - 6);

   logic [RB-1:0] disk_radius_ff;
   logic [RB-1:0] edge_width_ff;

   logic            vld_a_ff, vld_b_ff, vld_c_ff, vld_d_ff, vld_e_ff;
   logic [CB-1:0]   ax_ff, az_ff, h_a_ff;
   logic [2*CB-1:0] sqx_ff, sqz_ff;
   logic [CB-1:0]   h_b_ff;
   logic [2*CB-1:0] sum_ff;
   logic [CB-1:0]   h_c_ff;
   logic [DB-1:0]   d_ff;
   logic [CB-1:0]   h_d_ff;
   tsel_type        sel_e_ff;
   logic [RB-1:0]   num_e_ff;
   logic [CB-1:0]   h_e_ff;

   logic            accept;
   logic [CB-1:0]   ax_in, az_in;
   logic [DB-1:0]   inner;
   logic [RB-1:0]   edge_eff;
   tsel_type        sel_in;
   logic [RB-1:0]   num_in;

   logic            sq_valid;
   logic [CB-1:0]   sq_root;
   logic [CB-1:0]   sq_height;
   logic            dv_valid;
   logic [T_BITS-1:0] dv_quot;
   logic [SIDE_W-1:0] dv_side;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         disk_radius_ff <= RADIUS_RST;
         edge_width_ff  <= EDGE_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_DISK_RADIUS: disk_radius_ff <= csr_wdata;
            CSR_EDGE_WIDTH:  edge_width_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      ax_in    = req_x_coord[CB-1] ? (~req_x_coord + 1'b1) : req_x_coord;
      az_in    = req_z_coord[CB-1] ? (~req_z_coord + 1'b1) : req_z_coord;
      inner    = {3'b000, disk_radius_ff} - {3'b000, edge_width_ff};
      edge_eff = (edge_width_ff == '0) ? RB'(1) : edge_width_ff;
      sel_in.t_zero = d_ff[DB-1] || (d_ff == '0);
      sel_in.t_full = !sel_in.t_zero && (d_ff >= {3'b000, edge_eff});
      num_in   = (sel_in.t_zero || sel_in.t_full) ? '0 : d_ff[RB-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         vld_c_ff <= 1'b0;
         vld_d_ff <= 1'b0;
         vld_e_ff <= 1'b0;
      end else begin
         vld_a_ff <= accept;
         vld_b_ff <= vld_a_ff;
         vld_c_ff <= vld_b_ff;
         vld_d_ff <= sq_valid;
         vld_e_ff <= vld_d_ff;
      end
   end

   always_ff @(posedge clock) begin
      // magnitudes
      ax_ff    <= ax_in;
      az_ff    <= az_in;
      h_a_ff   <= req_height_in;
      // squares
      sqx_ff   <= ax_ff * ax_ff;
      sqz_ff   <= az_ff * az_ff;
      h_b_ff   <= h_a_ff;
      // sum of squares
      sum_ff   <= sqx_ff + sqz_ff;
      h_c_ff   <= h_b_ff;
      // distance into the falloff band
      d_ff     <= {2'b00, sq_root} - inner;
      h_d_ff   <= sq_height;
      // band classification
      sel_e_ff <= sel_in;
      num_e_ff <= num_in;
      h_e_ff   <= h_d_ff;
   end

   rshf_sqrt #(
      .RW     (CB),
      .SIDE_W (CB)
   ) u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (vld_c_ff),
      .in_radicand (sum_ff),
      .in_side     (h_c_ff),
      .out_valid   (sq_valid),
      .out_root    (sq_root),
      .out_side    (sq_height)
   );

   rshf_div #(
      .DW     (RB),
      .SIDE_W (SIDE_W)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (vld_e_ff),
      .in_dividend (num_e_ff),
      .divisor     (edge_eff),
      .in_side     ({h_e_ff, sel_e_ff}),
      .out_valid   (dv_valid),
      .out_quot    (dv_quot),
      .out_side    (dv_side)
   );

   rshf_shape #(
      .HW (CB)
   ) u_shape (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (dv_valid),
      .in_quot    (dv_quot),
      .in_sel     (tsel_type'(dv_side[SEL_W-1:0])),
      .in_height  (dv_side[SIDE_W-1:SEL_W]),
      .out_valid  (rsp_valid),
      .out_height (rsp_height_out)
   );

endmodule

@@ verif/radial_falloff_checker.sv @@
`timescale 1ns / 100ps
// checker for the radial smoothstep height falloff block: follows the csr writes,
// predicts height_out for each accepted transaction and compares results in order
// depends on rshf_pkg for the csr index names and the constants with 16 fraction bits (one in q1.16)
module radial_falloff_checker
   import rshf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          busy,
   input  logic [15:0]   req_x_coord,
   input  logic [15:0]   req_z_coord,
   input  logic [15:0]   req_height_in,
   input  logic          rsp_valid,
   input  logic [15:0]   rsp_height_out,
   input  logic          csr_write_en,
   input  csr_index_type csr_index,
   input  logic [14:0]   csr_wdata,
   output int            error_count,
   output int            outstanding,
   output int            transaction_count,
   output int            result_count
);

   logic [14:0] disk_radius_q;
   logic [14:0] edge_width_q;
   logic [15:0] expected_heights[$];
   int          errors_seen;
   int          accepted_seen;
   int          compared_seen;

   function automatic logic [15:0] attenuated_height(input logic signed [15:0] x,
                                                     input logic signed [15:0] z,
                                                     input logic signed [15:0] h,
                                                     input logic [14:0]        radius,
                                                     input logic [14:0]        band);
      longint ax, az, n, root, bit_q, inner, d, e, t, t2, s, h_mag, scaled;
      ax = (x < 0) ? -longint'(x) : longint'(x);
      az = (z < 0) ? -longint'(z) : longint'(z);
      n = ax * ax + az * az;
      // floor square root, one result bit per pass
      root = 0;
      bit_q = longint'(1) << 62;
      while (bit_q > n)
         bit_q = bit_q >> 2;
      while (bit_q != 0) begin
         if (n >= root + bit_q) begin
            n = n - (root + bit_q);
            root = (root >> 1) + bit_q;
         end else begin
            root = root >> 1;
         end
         bit_q = bit_q >> 2;
      end
      inner = longint'(radius) - longint'(band);
      d = root - inner;
      e = (band == 0) ? 1 : longint'(band);
      if (d <= 0)
         t = 0;
      else if (d >= e)
         t = longint'(ONE_T);
      else
         t = (d << T_BITS) / e;
      t2 = (t * t) >> T_BITS;
      s = (t2 * (longint'(THREE_T) - 2 * t)) >> T_BITS;
      if (s > longint'(ONE_T))
         s = longint'(ONE_T);
      h_mag = (h < 0) ? -longint'(h) : longint'(h);
      scaled = (h_mag * (longint'(ONE_T) - s) + longint'(HALF_T)) >> T_BITS;
      return (h < 0) ? 16'(-scaled) : 16'(scaled);
   endfunction

   always @(posedge clock) begin
      logic [15:0] oldest;
      if (reset) begin
         disk_radius_q <= 15'd8192;
         edge_width_q  <= 15'd1024;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_DISK_RADIUS: disk_radius_q <= csr_wdata;
               CSR_EDGE_WIDTH:  edge_width_q  <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (expected_heights.size() == 0) begin
               $error("unexpected result: height_out %0d with no transaction pending",
                      $signed(rsp_height_out));
               errors_seen++;
            end else begin
               oldest = expected_heights.pop_front();
               compared_seen++;
               if (rsp_height_out !== oldest) begin
                  $error("height_out mismatch: expected %0d actual %0d",
                         $signed(oldest), $signed(rsp_height_out));
                  errors_seen++;
               end
            end
         end
         if (start && !busy) begin
            expected_heights.insert(expected_heights.size(),
                                    attenuated_height(req_x_coord, req_z_coord,
                                                      req_height_in, disk_radius_q,
                                                      edge_width_q));
            accepted_seen++;
         end
      end
      error_count       <= errors_seen;
      outstanding       <= expected_heights.size();
      transaction_count <= accepted_seen;
      result_count      <= compared_seen;
   end

endmodule

@@ verif/tb_radial_smoothstep_height_falloff.sv @@
`timescale 1ns / 100ps
// testbench top for radial_smoothstep_height_falloff: clock, reset, csr settings and
// request stimulus with random gaps; checking is done by radial_falloff_checker
// depends on rshf_pkg, the block and radial_falloff_checker
module tb_radial_smoothstep_height_falloff;
   import rshf_pkg::*;

   localparam int NUM_SETTINGS       = 12;
   localparam int RANDOM_PER_SETTING = 160;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   logic [15:0]   req_x_coord = '0;
   logic [15:0]   req_z_coord = '0;
   logic [15:0]   req_height_in = '0;
   logic          rsp_valid;
   logic [15:0]   rsp_height_out;
   logic          csr_write_en = 1'b0;
   csr_index_type csr_index = CSR_DISK_RADIUS;
   logic [14:0]   csr_wdata = '0;

   int error_count;
   int outstanding;
   int transaction_count;
   int result_count;
   int burst_left = 0;

   always #4 clock = ~clock;

   radial_smoothstep_height_falloff #(
      .COORD_BITS(16)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_x_coord   (req_x_coord),
      .req_z_coord   (req_z_coord),
      .req_height_in (req_height_in),
      .rsp_valid     (rsp_valid),
      .rsp_height_out(rsp_height_out),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   radial_falloff_checker falloff_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_x_coord      (req_x_coord),
      .req_z_coord      (req_z_coord),
      .req_height_in    (req_height_in),
      .rsp_valid        (rsp_valid),
      .rsp_height_out   (rsp_height_out),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .error_count      (error_count),
      .outstanding      (outstanding),
      .transaction_count(transaction_count),
      .result_count     (result_count)
   );

   function automatic logic [15:0] clamp_coord(input int v);
      if (v < 0)
         return 16'd0;
      if (v > 32767)
         return 16'd32767;
      return 16'(v);
   endfunction

   task automatic send_item(input logic [15:0] x, input logic [15:0] z,
                            input logic [15:0] h);
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else begin
         gap = $urandom_range(0, 3);
         if ($urandom_range(0, 15) == 0)
            burst_left = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_x_coord   <= x;
      req_z_coord   <= z;
      req_height_in <= h;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_idle(input int settle);
      int spin;
      repeat (2) @(posedge clock);
      spin = 0;
      while (outstanding != 0 && spin < 4000) begin
         @(posedge clock);
         spin++;
      end
      repeat (settle) @(posedge clock);
   endtask

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      int radius_list[7] = '{8192, 4096, 1000, 32767, 0, 32767, 0};
      int band_list[7]   = '{1024, 0, 3000, 32767, 0, 0, 32767};
      int phase, n, radius_set, band_set, band_eff, inner, half, target, a, b, tmp;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (phase = 0; phase < NUM_SETTINGS; phase++) begin
         if (phase < 7) begin
            radius_set = radius_list[phase];
            band_set   = band_list[phase];
         end else begin
            radius_set = $urandom_range(0, 32767);
            band_set   = $urandom_range(0, 32767);
         end
         // csr writes only while the pipeline is empty
         csr_write_en <= 1'b1;
         csr_index    <= CSR_DISK_RADIUS;
         csr_wdata    <= 15'(radius_set);
         @(posedge clock);
         csr_index    <= CSR_EDGE_WIDTH;
         csr_wdata    <= 15'(band_set);
         @(posedge clock);
         csr_write_en <= 1'b0;
         band_eff = (band_set == 0) ? 1 : band_set;
         inner    = radius_set - band_set;
         half     = band_set / 2;
         if (phase < 3) begin
            // origin, far corner, band edges, exact half-way rounding ties, outer radius
            send_item(16'd0, 16'd0, 16'd0);
            send_item(16'h8000, 16'h8000, 16'h8000);
            send_item(clamp_coord(inner), 16'd0, 16'h7fff);
            send_item(clamp_coord(inner + 1), 16'd0, 16'h8000);
            send_item(16'd0, -clamp_coord(inner + half), 16'd1);
            send_item(clamp_coord(inner + half), 16'd0, 16'hffff);
            send_item(clamp_coord(radius_set - 1), 16'd0, 16'h7fff);
            send_item(16'd0, -clamp_coord(radius_set), 16'h8000);
         end
         for (n = 0; n < RANDOM_PER_SETTING; n++) begin
            if ($urandom_range(0, 3) == 0) begin
               send_item(16'($urandom), 16'($urandom), 16'($urandom));
            end else begin
               // aim the point at the falloff band, either near an axis or on a 3-4-5 ray
               target = inner + int'($urandom_range(0, band_eff)) +
                        int'($urandom_range(0, 8)) - 4;
               if (target < 0)
                  target = 0;
               if ($urandom_range(0, 1)) begin
                  a = target;
                  b = $urandom_range(0, 15);
               end else begin
                  a = target * 3 / 5;
                  b = target * 4 / 5;
               end
               a = clamp_coord(a);
               b = clamp_coord(b);
               if ($urandom_range(0, 1)) begin
                  tmp = a;
                  a = b;
                  b = tmp;
               end
               if ($urandom_range(0, 1))
                  a = -a;
               if ($urandom_range(0, 1))
                  b = -b;
               send_item(16'(a), 16'(b), 16'($urandom));
            end
         end
         start <= 1'b0;
         wait_idle((phase == NUM_SETTINGS - 1) ? 60 : 4);
      end
      $display("ran %0d transactions across %0d csr settings, %0d results compared",
               transaction_count, NUM_SETTINGS, result_count);
      $display("settings included zero edge, edge wider than radius and both extremes");
      if (outstanding != 0)
         $error("%0d expected results never arrived", outstanding);
      if (error_count == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
